/* src/assert_macros.svh */
// Assertion macros used by the date unit's pipeline control.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock, disabled while the active-low reset is low.
`define GJD_ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, on the block's own clock and reset.
`define GJD_ASSERT(lbl, prop, msg) `GJD_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

/* src/gjd_pkg.sv */
// Shared types, constants and tables of the Gregorian date unit.
package gjd_pkg;

  // Field widths.
  localparam int MonthW = 4;
  localparam int DayW   = 5;
  localparam int YearW  = 14;
  localparam int JdnW   = 23;
  localparam int YdayW  = 9;
  localparam int DistW  = 22;

  // Stream word widths, padded to whole bytes.
  localparam int InPadW   = 2;
  localparam int OutPadW  = 4;
  localparam int InWordW  = 2 * (MonthW + DayW + YearW) + InPadW;
  localparam int OutWordW = JdnW + YdayW + DistW + 2 * (MonthW + DayW + YearW) + OutPadW;

  // Pipeline depth: date to day number, one combining stage, day number to date.
  localparam int ToJdnLat   = 3;
  localparam int FromJdnLat = 8;
  localparam int NumStages  = ToJdnLat + 1 + FromJdnLat;

  typedef logic [JdnW-1:0]      jdn_t;
  typedef logic [NumStages-1:0] stage_en_t;

  // A calendar date, month in the lowest bits.
  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
  } date_t;

  typedef struct packed {
    logic [InPadW-1:0] pad;
    date_t             other_date;
    date_t             main_date;
  } in_word_t;

  typedef struct packed {
    logic [OutPadW-1:0] pad;
    date_t              prior_date;
    date_t              next_date;
    logic [DistW-1:0]   distance_days;
    logic [YdayW-1:0]   year_day;
    jdn_t               day_number;
  } out_word_t;

  // Forward conversion constants.
  localparam int JdnBias       = 32075;
  localparam int EpochYear     = 4800;
  localparam int CenturyBase   = 4900;
  localparam int DaysPer4Years = 1461;

  // Division by 100 as a reciprocal multiply; exact for dividends below 2**15.
  localparam int          Div100Shift = 22;
  localparam logic [15:0] Div100Mul   = 16'(((64'd1 << Div100Shift) + 64'd99) / 64'd100);

  // Inverse conversion constants.
  localparam int JdnShift      = 68569;
  localparam int DaysPer400Yrs = 146097;
  localparam int YearScale     = 4000;
  localparam int DayAdjust     = 31;
  localparam int MonthLenNum   = 2447;
  localparam int MonthLenDen   = 80;
  localparam int MonthsPerYear = 12;
  localparam int CenturyOffset = 4900;

  // floor(4*l / 146097) as l * NDivMul >> NDivShift; exact for 4*l below 2**25.
  localparam int          NDivShift = 41;
  localparam logic [25:0] NDivMul   = 26'(((64'd1 << (NDivShift + 2)) + 64'd146096) / 64'd146097);

  // floor(x / 1461001) as x * IDivMul >> IDivShift; exact for x below 2**28.
  localparam int          IDivShift = 49;
  localparam logic [28:0] IDivMul   = 29'(((64'd1 << IDivShift) + 64'd1461000) / 64'd1461001);

  // floor(80*l / 2447) as l * JDivMul80 >> JDivShift; exact for 80*l below 2**16.
  localparam int          JDivShift = 28;
  localparam logic [23:0] JDivMul80 =
    24'(64'd80 * (((64'd1 << JDivShift) + 64'd2446) / 64'd2447));

  // 367 * (m - 2 - 12*a) / 12 with a = -1 for months 0 to 2 (so January and February), 0 otherwise.
  function automatic logic [8:0] month_offset(logic [MonthW-1:0] m);
    logic [8:0] r;
    unique case (m)
      4'd0:  r = 9'd305;
      4'd1:  r = 9'd336;
      4'd2:  r = 9'd367;
      4'd3:  r = 9'd30;
      4'd4:  r = 9'd61;
      4'd5:  r = 9'd91;
      4'd6:  r = 9'd122;
      4'd7:  r = 9'd152;
      4'd8:  r = 9'd183;
      4'd9:  r = 9'd214;
      4'd10: r = 9'd244;
      4'd11: r = 9'd275;
      4'd12: r = 9'd305;
      4'd13: r = 9'd336;
      4'd14: r = 9'd367;
      4'd15: r = 9'd397;
    endcase
    return r;
  endfunction

  // 2447 * j / 80, the days before month index j of the shifted year.
  function automatic logic [8:0] month_start(logic [3:0] j);
    logic [8:0] r;
    unique case (j)
      4'd0:  r = 9'd0;
      4'd1:  r = 9'd30;
      4'd2:  r = 9'd61;
      4'd3:  r = 9'd91;
      4'd4:  r = 9'd122;
      4'd5:  r = 9'd152;
      4'd6:  r = 9'd183;
      4'd7:  r = 9'd214;
      4'd8:  r = 9'd244;
      4'd9:  r = 9'd275;
      4'd10: r = 9'd305;
      4'd11: r = 9'd336;
      4'd12: r = 9'd367;
      4'd13: r = 9'd397;
      4'd14: r = 9'd428;
      4'd15: r = 9'd458;
    endcase
    return r;
  endfunction

endpackage

/* src/gjd_pipe_ctrl.sv */
// Valid tracking and per-stage load enables of the date unit's pipeline.
`include "assert_macros.svh"

module gjd_pipe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output gjd_pkg::stage_en_t en_o
);

  localparam gjd_pkg::stage_en_t AllStages = '1;

  gjd_pkg::stage_en_t valid_q, valid_d, feed;

  // A stage holds only when it and every stage after it hold a word
  // and the output word is not being taken.
  always_comb begin
    for (int k = 0; k < gjd_pkg::NumStages; k++) begin
      en_o[k] = m_tready_i || !(&(valid_q | ~(AllStages << k)));
    end
  end

  assign feed    = {valid_q[gjd_pkg::NumStages-2:0], s_tvalid_i};
  assign valid_d = (en_o & feed) | (~en_o & valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign s_tready_o = en_o[0];
  assign m_tvalid_o = valid_q[gjd_pkg::NumStages-1];

  `GJD_ASSERT(a_empty_out_takes_in, !m_tvalid_o |-> s_tready_o, "input stalled with an empty output stage")
  `GJD_ASSERT(a_drain_takes_in, (m_tvalid_o && m_tready_i) |-> s_tready_o, "input stalled while output drains")
  `GJD_ASSERT(a_word_count, 1'b1 |=> ($countones(valid_q) == $past($countones(valid_q)) + int'($past(s_tvalid_i && s_tready_o)) - int'($past(m_tvalid_o && m_tready_i))), "pipeline lost or duplicated a word")

endmodule

/* src/gjd_to_jdn.sv */
// Three-stage pipelined conversion of a Gregorian date to its Julian day number.
module gjd_to_jdn (
  input  logic                          clk_i,
  input  logic [gjd_pkg::ToJdnLat-1:0]  en_i,
  input  gjd_pkg::date_t                date_i,
  output gjd_pkg::jdn_t                 jdn_o
);

  // Stage 1: year offsets and the month term.
  logic        early;
  logic [14:0] x1_d, x1_q, x3_d, x3_q;
  logic [8:0]  t2_d, t2_q;
  logic [4:0]  day_q;

  // Stage 2: the two multiplications.
  logic [25:0] p1_d, p1_q;
  logic [30:0] p3_d, p3_q;
  logic [8:0]  t2b_q;
  logic [4:0]  dayb_q;

  // Stage 3: sum of the terms.
  logic [23:0] t1;
  logic [8:0]  q100;
  logic [10:0] q3;
  logic [8:0]  t3;
  logic [23:0] pos_sum, neg_sum;
  gjd_pkg::jdn_t jdn_d, jdn_q;

  always_comb begin
    // January and February count as months 13 and 14 of the previous year.
    early = (date_i.month <= 4'd2);
    x1_d  = 15'(date_i.year) + (early ? 15'(gjd_pkg::EpochYear - 1) : 15'(gjd_pkg::EpochYear));
    x3_d  = 15'(date_i.year) + (early ? 15'(gjd_pkg::CenturyBase - 1)
                                      : 15'(gjd_pkg::CenturyBase));
    t2_d  = gjd_pkg::month_offset(date_i.month);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      x1_q  <= x1_d;
      x3_q  <= x3_d;
      t2_q  <= t2_d;
      day_q <= date_i.day;
    end
  end

  always_comb begin
    p1_d = 26'(x1_q) * 26'(gjd_pkg::DaysPer4Years);
    p3_d = 31'(x3_q) * 31'(gjd_pkg::Div100Mul);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      p1_q   <= p1_d;
      p3_q   <= p3_d;
      t2b_q  <= t2_q;
      dayb_q <= day_q;
    end
  end

  always_comb begin
    t1      = p1_q[25:2];
    q100    = p3_q[30:22];
    q3      = 11'(q100) + 11'({q100, 1'b0});
    t3      = q3[10:2];
    pos_sum = t1 + 24'(dayb_q) + 24'(t2b_q);
    neg_sum = 24'(t3) + 24'(gjd_pkg::JdnBias);
    jdn_d   = gjd_pkg::JdnW'(pos_sum - neg_sum);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      jdn_q <= jdn_d;
    end
  end

  assign jdn_o = jdn_q;

endmodule

/* src/gjd_from_jdn.sv */
// Eight-stage pipelined conversion of a Julian day number back to a Gregorian date.
module gjd_from_jdn (
  input  logic                            clk_i,
  input  logic [gjd_pkg::FromJdnLat-1:0]  en_i,
  input  gjd_pkg::jdn_t                   jdn_i,
  output gjd_pkg::date_t                  date_o
);

  // Stage 1: shifted day count.
  gjd_pkg::jdn_t l1_d, l1_q;
  // Stage 2: 400-year cycle index.
  logic [48:0]   prod_n;
  logic [7:0]    n2_d, n2_q;
  gjd_pkg::jdn_t l2a_q;
  // Stage 3: day within the cycle.
  logic [25:0]   cyc;
  logic [23:0]   l2w;
  logic [15:0]   l3a_d, l3a_q;
  logic [7:0]    n3_q;
  // Stage 4: scaled day for the year index.
  logic [16:0]   lp1;
  logic [27:0]   xi_d, xi_q;
  logic [15:0]   l4a_q;
  logic [7:0]    n4_q;
  // Stage 5: year index within the cycle.
  logic [56:0]   prod_i;
  logic [6:0]    i5_d, i5_q;
  logic [15:0]   l5a_q;
  logic [7:0]    n5_q;
  // Stage 6: day within the shifted year.
  logic [17:0]   li;
  logic [16:0]   l3w;
  logic [8:0]    l6_d, l6_q;
  logic [6:0]    i6_q;
  logic [7:0]    n6_q;
  // Stage 7: shifted month index.
  logic [32:0]   prod_j;
  logic [3:0]    j7_d, j7_q;
  logic [8:0]    l7_q;
  logic [6:0]    i7_q;
  logic [7:0]    n7_q;
  // Stage 8: the date itself.
  logic          wrap;
  logic [8:0]    kw;
  logic [15:0]   yw;
  gjd_pkg::date_t date_d, date_q;

  assign l1_d = jdn_i + gjd_pkg::JdnW'(gjd_pkg::JdnShift);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      l1_q <= l1_d;
    end
  end

  always_comb begin
    prod_n = 49'(l1_q) * 49'(gjd_pkg::NDivMul);
    n2_d   = prod_n[48:41];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      n2_q  <= n2_d;
      l2a_q <= l1_q;
    end
  end

  always_comb begin
    cyc   = 26'(n2_q) * 26'(gjd_pkg::DaysPer400Yrs) + 26'd3;
    l2w   = 24'(l2a_q) - cyc[25:2];
    l3a_d = l2w[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      l3a_q <= l3a_d;
      n3_q  <= n2_q;
    end
  end

  always_comb begin
    lp1  = 17'(l3a_q) + 17'd1;
    xi_d = 28'(lp1) * 28'(gjd_pkg::YearScale);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      xi_q  <= xi_d;
      l4a_q <= l3a_q;
      n4_q  <= n3_q;
    end
  end

  always_comb begin
    prod_i = 57'(xi_q) * 57'(gjd_pkg::IDivMul);
    i5_d   = prod_i[55:49];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      i5_q  <= i5_d;
      l5a_q <= l4a_q;
      n5_q  <= n4_q;
    end
  end

  always_comb begin
    li   = 18'(i5_q) * 18'(gjd_pkg::DaysPer4Years);
    l3w  = 17'(l5a_q) + 17'(gjd_pkg::DayAdjust) - 17'(li[17:2]);
    l6_d = l3w[8:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      l6_q <= l6_d;
      i6_q <= i5_q;
      n6_q <= n5_q;
    end
  end

  always_comb begin
    prod_j = 33'(l6_q) * 33'(gjd_pkg::JDivMul80);
    j7_d   = prod_j[31:28];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      j7_q <= j7_d;
      l7_q <= l6_q;
      i7_q <= i6_q;
      n7_q <= n6_q;
    end
  end

  // Month indices 11 and up belong to January and February of the next year.
  always_comb begin
    wrap         = (j7_q >= 4'd11);
    kw           = l7_q - gjd_pkg::month_start(j7_q);
    date_d.day   = kw[4:0];
    date_d.month = j7_q + 4'd2 - (wrap ? 4'(gjd_pkg::MonthsPerYear) : 4'd0);
    yw           = 16'(n7_q) * 16'd100 + 16'(i7_q) + 16'(wrap)
                   - 16'(gjd_pkg::CenturyOffset);
    date_d.year  = yw[13:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      date_q <= date_d;
    end
  end

  assign date_o = date_q;

endmodule

/* src/gregorian_julian_day_unit.sv */
// Top level of the Gregorian date unit: takes a date and a comparison date and returns
// the date's Julian day number, its day of the year, the distance in days to the
// comparison date, and the dates of the following and the preceding day. Each day
// number comes from the classic integer formula for Julian day numbers, and the
// neighboring dates from its inverse applied to the day number plus and minus one.
// Input words enter on the s_ group and results leave on the m_ group; a word moves on
// a rising clock edge at which tvalid and tready are both high. The unit is a
// twelve-stage pipeline: three stages turn a date into a day number, one stage forms
// the day of the year, the distance and the neighboring day numbers, and eight stages
// turn a day number back into a date. It takes one input word per clock cycle while
// s_tready_o is high. The result of each word passes through the twelve pipeline
// registers before it shows on m_tdata_o and is handed over. Each stage of the
// pipeline advances unless it and all stages after it
// hold words and the output word is not taken, so empty stages are filled while a
// result waits, and s_tready_o falls only when all twelve stages hold words. Dates are
// not checked: a month, day or year outside the calendar gives the formula's raw
// result, cut to the width of each output field. There are no configuration registers
// and no stored state besides the pipeline itself.
module gregorian_julian_day_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  // Fields from bit 0 up: date_month, date_day, date_year, other_month, other_day,
  // other_year, then two zero bits.
  input  logic [gjd_pkg::InWordW-1:0]    s_tdata_i,
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  // Fields from bit 0 up: day_number, year_day, distance_days, next_month, next_day,
  // next_year, prior_month, prior_day, prior_year, then four zero bits.
  output logic [gjd_pkg::OutWordW-1:0]   m_tdata_o
);

  localparam int CombStage = gjd_pkg::ToJdnLat;
  localparam int FromStage = CombStage + 1;

  // Fields that ride alongside the inverse conversion.
  typedef struct packed {
    gjd_pkg::jdn_t               jdn;
    logic [gjd_pkg::YdayW-1:0]   yday;
    logic [gjd_pkg::DistW-1:0]   distance;
  } keep_t;

  gjd_pkg::stage_en_t en;
  gjd_pkg::in_word_t  in_word;
  gjd_pkg::out_word_t out_word;
  gjd_pkg::date_t     start_date, next_date, prior_date;
  gjd_pkg::jdn_t      jdn_main, jdn_other, jdn_start;

  gjd_pkg::jdn_t              jd_d, jd_q, jd_next_d, jd_next_q, jd_prior_d, jd_prior_q;
  gjd_pkg::jdn_t              yd_full, diff;
  logic [gjd_pkg::YdayW-1:0]  yday_d, yday_q;
  logic [gjd_pkg::DistW-1:0]  dist_d, dist_q;
  keep_t                      keep_d;
  keep_t                      keep_q [gjd_pkg::FromJdnLat];

  gjd_pipe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .en_o       (en)
  );

  assign in_word = gjd_pkg::in_word_t'(s_tdata_i);

  // January 1 of the main date's year, for the day of the year.
  always_comb begin
    start_date.year  = in_word.main_date.year;
    start_date.day   = 5'd1;
    start_date.month = 4'd1;
  end

  gjd_to_jdn u_to_main (
    .clk_i  (clk_i),
    .en_i   (en[CombStage-1:0]),
    .date_i (in_word.main_date),
    .jdn_o  (jdn_main)
  );

  gjd_to_jdn u_to_other (
    .clk_i  (clk_i),
    .en_i   (en[CombStage-1:0]),
    .date_i (in_word.other_date),
    .jdn_o  (jdn_other)
  );

  gjd_to_jdn u_to_start (
    .clk_i  (clk_i),
    .en_i   (en[CombStage-1:0]),
    .date_i (start_date),
    .jdn_o  (jdn_start)
  );

  // Combining stage. All day numbers are positive and well inside 23 bits for any
  // input pattern, so the wrap of the narrower fields is just their low bits.
  always_comb begin
    jd_d       = jdn_main;
    yd_full    = jdn_main - jdn_start + gjd_pkg::JdnW'(1);
    yday_d     = yd_full[gjd_pkg::YdayW-1:0];
    diff       = (jdn_other > jdn_main) ? (jdn_other - jdn_main) : (jdn_main - jdn_other);
    dist_d     = diff[gjd_pkg::DistW-1:0];
    jd_next_d  = jdn_main + gjd_pkg::JdnW'(1);
    jd_prior_d = jdn_main - gjd_pkg::JdnW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (en[CombStage]) begin
      jd_q       <= jd_d;
      yday_q     <= yday_d;
      dist_q     <= dist_d;
      jd_next_q  <= jd_next_d;
      jd_prior_q <= jd_prior_d;
    end
  end

  gjd_from_jdn u_from_next (
    .clk_i  (clk_i),
    .en_i   (en[gjd_pkg::NumStages-1:FromStage]),
    .jdn_i  (jd_next_q),
    .date_o (next_date)
  );

  gjd_from_jdn u_from_prior (
    .clk_i  (clk_i),
    .en_i   (en[gjd_pkg::NumStages-1:FromStage]),
    .jdn_i  (jd_prior_q),
    .date_o (prior_date)
  );

  // Delay line that keeps the early results in step with the inverse conversion.
  always_comb begin
    keep_d.jdn      = jd_q;
    keep_d.yday     = yday_q;
    keep_d.distance = dist_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[FromStage]) begin
      keep_q[0] <= keep_d;
    end
    for (int k = 1; k < gjd_pkg::FromJdnLat; k++) begin
      if (en[FromStage + k]) begin
        keep_q[k] <= keep_q[k-1];
      end
    end
  end

  always_comb begin
    out_word.pad           = '0;
    out_word.prior_date    = prior_date;
    out_word.next_date     = next_date;
    out_word.distance_days = keep_q[gjd_pkg::FromJdnLat-1].distance;
    out_word.year_day      = keep_q[gjd_pkg::FromJdnLat-1].yday;
    out_word.day_number    = keep_q[gjd_pkg::FromJdnLat-1].jdn;
  end

  assign m_tdata_o = out_word;

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the Gregorian date unit: directed dates, then random ones.
module testbench;

  // Silence on both sides for as long as HangLimit allows means the pipeline hung.
  localparam int HangLimit  = 2000;
  localparam int RandWords  = 400;
  localparam int IdlePct    = 7;
  localparam int MaxReports = 100;

  // One row of the directed table: the input word and, where it can be typed in,
  // the result it must produce.
  typedef struct {
    gjd_pkg::in_word_t  word;
    bit                 typed;
    gjd_pkg::out_word_t want;
  } stim_row_t;

  logic                         clk_i      = 1'b0;
  logic                         rst_ni     = 1'b0;
  logic                         s_tvalid_i = 1'b0;
  logic                         s_tready_o;
  // Fields from bit 0 up: date_month, date_day, date_year, other_month, other_day,
  // other_year, then two zero bits.
  logic [gjd_pkg::InWordW-1:0]  s_tdata_i  = '0;
  logic                         m_tvalid_o;
  logic                         m_tready_i = 1'b0;
  // Fields from bit 0 up: day_number, year_day, distance_days, next_month, next_day,
  // next_year, prior_month, prior_day, prior_year, then four zero bits.
  logic [gjd_pkg::OutWordW-1:0] m_tdata_o;

  // Results owed by the unit, oldest first.
  gjd_pkg::out_word_t conversions_due[$];
  stim_row_t          directed_rows[$];
  int                 errors    = 0;
  int                 quiet_cyc = 0;
  // While set, neither side of the stream idles.
  bit                 steady    = 1'b0;
  gjd_pkg::out_word_t got_word;
  gjd_pkg::out_word_t want_word;

  gregorian_julian_day_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Integer formula: calendar date to day number. SystemVerilog division on
  // signed operands truncates toward zero, which is what the formula relies on.
  function automatic longint jdn_of_date(longint m, longint d, longint y);
    longint a;
    a = (m - 14) / 12;
    return d - gjd_pkg::JdnBias
         + gjd_pkg::DaysPer4Years * (y + gjd_pkg::EpochYear + a) / 4
         + 367 * (m - 2 - a * 12) / 12
         - 3 * ((y + gjd_pkg::CenturyBase + a) / 100) / 4;
  endfunction

  // Inverse formula: day number back to a calendar date.
  function automatic gjd_pkg::date_t date_of_jdn(longint jd);
    longint         l, n, i, j, k;
    gjd_pkg::date_t r;
    l = jd + gjd_pkg::JdnShift;
    n = 4 * l / gjd_pkg::DaysPer400Yrs;
    l = l - (gjd_pkg::DaysPer400Yrs * n + 3) / 4;
    i = gjd_pkg::YearScale * (l + 1) / 1461001;
    l = l - gjd_pkg::DaysPer4Years * i / 4 + gjd_pkg::DayAdjust;
    j = gjd_pkg::MonthLenDen * l / gjd_pkg::MonthLenNum;
    k = l - gjd_pkg::MonthLenNum * j / gjd_pkg::MonthLenDen;
    l = j / 11;
    j = j + 2 - gjd_pkg::MonthsPerYear * l;
    i = 100 * (n - 49) + i + l;
    r.year  = i[gjd_pkg::YearW-1:0];
    r.month = j[gjd_pkg::MonthW-1:0];
    r.day   = k[gjd_pkg::DayW-1:0];
    return r;
  endfunction

  // Full prediction of one result word; every field is the low bits of the raw value.
  function automatic gjd_pkg::out_word_t convert_dates(gjd_pkg::in_word_t w);
    longint             jd, jo, jan1, span, yday;
    gjd_pkg::out_word_t o;
    jd   = jdn_of_date(longint'(w.main_date.month), longint'(w.main_date.day),
                       longint'(w.main_date.year));
    jo   = jdn_of_date(longint'(w.other_date.month), longint'(w.other_date.day),
                       longint'(w.other_date.year));
    jan1 = jdn_of_date(1, 1, longint'(w.main_date.year));
    span = (jo > jd) ? jo - jd : jd - jo;
    yday = jd - jan1 + 1;
    o               = '0;
    o.day_number    = jd[gjd_pkg::JdnW-1:0];
    o.year_day      = yday[gjd_pkg::YdayW-1:0];
    o.distance_days = span[gjd_pkg::DistW-1:0];
    o.next_date     = date_of_jdn(jd + 1);
    o.prior_date    = date_of_jdn(jd - 1);
    return o;
  endfunction

  function automatic gjd_pkg::in_word_t pack_dates(int m, int d, int y,
                                                   int om, int od, int oy);
    gjd_pkg::in_word_t w;
    w                  = '0;
    w.main_date.month  = m[gjd_pkg::MonthW-1:0];
    w.main_date.day    = d[gjd_pkg::DayW-1:0];
    w.main_date.year   = y[gjd_pkg::YearW-1:0];
    w.other_date.month = om[gjd_pkg::MonthW-1:0];
    w.other_date.day   = od[gjd_pkg::DayW-1:0];
    w.other_date.year  = oy[gjd_pkg::YearW-1:0];
    return w;
  endfunction

  function automatic gjd_pkg::date_t mk_date(int m, int d, int y);
    gjd_pkg::date_t r;
    r.month = m[gjd_pkg::MonthW-1:0];
    r.day   = d[gjd_pkg::DayW-1:0];
    r.year  = y[gjd_pkg::YearW-1:0];
    return r;
  endfunction

  function automatic int month_len(int m, int y);
    bit leap;
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    case (m)
      2:             return leap ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  // A random date: mostly a valid calendar date, often the last day of a month so
  // that month and year rollovers come up, sometimes raw bits over the whole field.
  function automatic gjd_pkg::date_t random_date();
    int             m, d, y, pick;
    gjd_pkg::date_t r;
    pick = $urandom_range(99);
    if (pick < 12) begin
      r = gjd_pkg::date_t'($urandom_range(
            2 ** (gjd_pkg::MonthW + gjd_pkg::DayW + gjd_pkg::YearW) - 1));
    end else begin
      case ($urandom_range(9))
        0:       y = $urandom_range(1, 30);
        1:       y = $urandom_range(9970, 9999);
        2:       y = 100 * $urandom_range(1, 99);
        default: y = $urandom_range(1, 9999);
      endcase
      m = $urandom_range(1, 12);
      d = ($urandom_range(99) < 30) ? month_len(m, y)
        : ($urandom_range(99) < 15) ? 1 : $urandom_range(1, month_len(m, y));
      r = mk_date(m, d, y);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (errors < MaxReports)
      $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic check_result(gjd_pkg::out_word_t got, gjd_pkg::out_word_t want);
    if (got.day_number != want.day_number)
      report_mismatch("day_number", got.day_number, want.day_number);
    if (got.year_day != want.year_day)
      report_mismatch("year_day", got.year_day, want.year_day);
    if (got.distance_days != want.distance_days)
      report_mismatch("distance_days", got.distance_days, want.distance_days);
    if (got.next_date.month != want.next_date.month)
      report_mismatch("next_month", got.next_date.month, want.next_date.month);
    if (got.next_date.day != want.next_date.day)
      report_mismatch("next_day", got.next_date.day, want.next_date.day);
    if (got.next_date.year != want.next_date.year)
      report_mismatch("next_year", got.next_date.year, want.next_date.year);
    if (got.prior_date.month != want.prior_date.month)
      report_mismatch("prior_month", got.prior_date.month, want.prior_date.month);
    if (got.prior_date.day != want.prior_date.day)
      report_mismatch("prior_day", got.prior_date.day, want.prior_date.day);
    if (got.prior_date.year != want.prior_date.year)
      report_mismatch("prior_year", got.prior_date.year, want.prior_date.year);
    if (got.pad != '0)
      report_mismatch("padding", got.pad, 0);
  endtask

  // Offers one word on the input side, starting at a falling edge. Valid is only
  // lowered by an idle cycle, so back-to-back words keep it high without a glitch.
  // Returns at the falling edge after the word was taken.
  task automatic offer_word(gjd_pkg::in_word_t word, gjd_pkg::out_word_t want);
    while (!steady && $urandom_range(99) < IdlePct) begin
      s_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= word;
    do @(posedge clk_i); while (!s_tready_o);
    conversions_due.push_back(want);
    @(negedge clk_i);
  endtask

  // The output side stalls at random, except during the steady stretch.
  always @(negedge clk_i) begin
    m_tready_i <= steady || ($urandom_range(99) >= IdlePct);
  end

  // Every result taken is compared with the oldest one owed.
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      got_word = gjd_pkg::out_word_t'(m_tdata_o);
      if (conversions_due.size() == 0) begin
        report_mismatch("unexpected result, day_number", got_word.day_number, 0);
      end else begin
        want_word = conversions_due.pop_front();
        check_result(got_word, want_word);
      end
    end
  end

  // Ends the run if neither side moves a word for too long.
  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) begin
      quiet_cyc <= 0;
    end else if (quiet_cyc >= HangLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cyc <= quiet_cyc + 1;
    end
  end

  initial begin
    stim_row_t row;

    // Directed dates. The three typed rows are the epoch of the calendar range, its
    // far end, and the turn of the year 2000; the rest go through the predictor.
    row.typed = 1'b1;
    row.word  = pack_dates(1, 1, 2000, 1, 1, 2000);
    row.want  = '{pad: '0, day_number: 23'd2451545, year_day: 9'd1, distance_days: 22'd0,
                  next_date: mk_date(1, 2, 2000), prior_date: mk_date(12, 31, 1999)};
    directed_rows.push_back(row);
    row.word  = pack_dates(1, 1, 1, 12, 31, 9999);
    row.want  = '{pad: '0, day_number: 23'd1721426, year_day: 9'd1,
                  distance_days: 22'd3652058,
                  next_date: mk_date(1, 2, 1), prior_date: mk_date(12, 31, 0)};
    directed_rows.push_back(row);
    row.word  = pack_dates(12, 31, 9999, 1, 1, 1);
    row.want  = '{pad: '0, day_number: 23'd5373484, year_day: 9'd365,
                  distance_days: 22'd3652058,
                  next_date: mk_date(1, 1, 10000), prior_date: mk_date(12, 30, 9999)};
    directed_rows.push_back(row);

    row.typed = 1'b0;
    row.want  = '0;
    // Leap days and century rules.
    row.word = pack_dates(2, 29, 2000, 3, 1, 2000);   directed_rows.push_back(row);
    row.word = pack_dates(2, 28, 1900, 2, 28, 2004);  directed_rows.push_back(row);
    row.word = pack_dates(2, 28, 2004, 2, 28, 1900);  directed_rows.push_back(row);
    row.word = pack_dates(3, 1, 2000, 2, 29, 2000);   directed_rows.push_back(row);
    row.word = pack_dates(12, 31, 2000, 1, 1, 2001);  directed_rows.push_back(row);
    row.word = pack_dates(3, 1, 2100, 2, 28, 2100);   directed_rows.push_back(row);
    row.word = pack_dates(6, 15, 1970, 6, 15, 1970);  directed_rows.push_back(row);
    // Dates outside the calendar: zero fields, all-ones fields, overlong months.
    row.word = pack_dates(0, 0, 0, 0, 0, 0);          directed_rows.push_back(row);
    row.word = pack_dates(15, 31, 16383, 0, 0, 0);    directed_rows.push_back(row);
    row.word = pack_dates(0, 0, 0, 15, 31, 16383);    directed_rows.push_back(row);
    row.word = pack_dates(13, 5, 2020, 14, 1, 2020);  directed_rows.push_back(row);
    row.word = pack_dates(2, 30, 2021, 4, 31, 2021);  directed_rows.push_back(row);
    row.word = pack_dates(1, 0, 0, 12, 31, 0);        directed_rows.push_back(row);
    row.word = pack_dates(12, 31, 16383, 1, 1, 10000); directed_rows.push_back(row);
    // Alternating bit patterns in every field.
    row.word = pack_dates(10, 21, 10922, 5, 10, 5461); directed_rows.push_back(row);
    row.word = pack_dates(5, 10, 5461, 10, 21, 10922); directed_rows.push_back(row);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      offer_word(directed_rows[i].word,
                 directed_rows[i].typed ? directed_rows[i].want
                                        : convert_dates(directed_rows[i].word));

    // Random dates, with a stretch in the middle where neither side idles.
    for (int n = 0; n < RandWords; n++) begin
      gjd_pkg::in_word_t w;
      w            = '0;
      steady       = (n >= 150) && (n < 260);
      w.main_date  = random_date();
      w.other_date = ($urandom_range(99) < 5) ? w.main_date : random_date();
      offer_word(w, convert_dates(w));
    end
    steady     = 1'b0;
    s_tvalid_i <= 1'b0;

    // Drain the pipeline, then give it time to show any stray result.
    while (conversions_due.size() != 0) @(posedge clk_i);
    repeat (gjd_pkg::NumStages + 8) @(posedge clk_i);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
